/* rtl/core/sliding_window_median_top_assert.svh */
// Assertion macros for the sliding window median block and its checker.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef SLIDING_WINDOW_MEDIAN_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SWM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sliding window median: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sliding window median: next-cycle check failed");

`endif

/* rtl/core/swm_pkg.sv */
// Shared types and constants of the sliding window median block.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package swm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MED_W    = 17;
  localparam int COUNT_W  = 6;

  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CAND_RD = 6'b000010,
    S_CAND_LD = 6'b000100,
    S_SCAN    = 6'b001000,
    S_CHECK   = 6'b010000,
    S_FIN     = 6'b100000
  } state_t;

endpackage

/* rtl/core/sliding_window_median_top.sv */
// Sliding window median filter: top level with ring memory and rank sequencer.
// Depends on swm_pkg.
`timescale 1ns / 1ps

// Usage
//  Input channel item_valid/item_ready carries kind and sample. kind push
//  writes sample into the next ring slot (WINDOW slots, filling from slot 0)
//  and raises the fill count up to WINDOW; kind clear empties the window
//  and yields no result.
//  Output channel result_valid/result_ready carries median_doubled (twice
//  the median, sum of the two middle samples for an even count) and
//  fill_count, one transfer per push.
//  A push loads the result register as the sequencer finishes ranking
//  the held samples; item_ready returns then.
//  Each held sample is ranked in turn against all held samples through one
//  signed comparator fed by the single registered read port of the ring
//  memory: one read for the candidate, n compare reads, one rank check.
//  A clear leaves the sequencer idle. item_ready is high only while the sequencer idles.
//  Stall: the result register holds its transfer until result_ready; the
//  sequencer may accept and finish the next item meanwhile but holds its
//  final step until the register is free.
//  Reset: synchronous, active high; the window reads as empty afterwards
//  through the fill count, so the memory needs no clearing pass.
module sliding_window_median_top #(
  parameter int WINDOW = 5
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic                                 kind,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  sample,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic signed [swm_pkg::MED_W-1:0]     median_doubled,
  output logic        [swm_pkg::COUNT_W-1:0]   fill_count
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);

  // Ring memory, one write and one registered read port.
  logic signed [swm_pkg::SAMPLE_W-1:0] ring [WINDOW];
  logic signed [swm_pkg::SAMPLE_W-1:0] rd_data;
  logic        [AW-1:0]                rd_addr;
  logic                                wr_en;

  swm_pkg::state_t state;

  logic [AW-1:0] wpos;       // next slot to write
  logic [CW-1:0] held;       // samples held, saturates at WINDOW
  logic [AW-1:0] cand_idx;   // slot being ranked
  logic [CW-1:0] scan_idx;   // next slot to read during the scan
  logic [CW-1:0] less_cnt;   // held samples below the candidate
  logic [CW-1:0] le_cnt;     // held samples at or below the candidate
  logic signed [swm_pkg::SAMPLE_W-1:0] cand;
  logic signed [swm_pkg::SAMPLE_W-1:0] lo_val;
  logic signed [swm_pkg::SAMPLE_W-1:0] hi_val;

  logic          item_xfer;
  logic          result_xfer;
  logic [CW-1:0] rank_lo;
  logic [CW-1:0] rank_hi;
  logic          cmp_less;
  logic          cmp_le;
  logic          out_free;

  assign item_ready  = (state == swm_pkg::S_IDLE);
  assign item_xfer   = item_valid && item_ready;
  assign result_xfer = result_valid && result_ready;
  assign out_free    = !result_valid || result_ready;
  assign wr_en       = item_xfer && (kind == swm_pkg::KIND_PUSH);

  // Middle ranks: equal for an odd count, adjacent for an even count.
  assign rank_lo = (held - CW'(1)) >> 1;
  assign rank_hi = held >> 1;

  // The shared comparator.
  assign cmp_less = (rd_data < cand);
  assign cmp_le   = (rd_data <= cand);

  // Read the candidate slot first, then sweep the held slots.
  always_comb begin
    if (state == swm_pkg::S_CAND_RD) begin
      rd_addr = cand_idx;
    end else if (scan_idx < CW'(WINDOW)) begin
      rd_addr = scan_idx[AW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wpos] <= sample;
    end
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= swm_pkg::S_IDLE;
      wpos         <= '0;
      held         <= '0;
      cand_idx     <= '0;
      scan_idx     <= '0;
      result_valid <= 1'b0;
    end else begin
      // Drop the result once the receiver takes it.
      if (result_xfer) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        swm_pkg::S_IDLE: begin
          if (item_xfer) begin
            if (kind == swm_pkg::KIND_CLEAR) begin
              wpos <= '0;
              held <= '0;
            end else begin
              wpos     <= (wpos == AW'(WINDOW - 1)) ? '0 : wpos + AW'(1);
              held     <= (held == CW'(WINDOW)) ? held : held + CW'(1);
              cand_idx <= '0;
              state    <= swm_pkg::S_CAND_RD;
            end
          end
        end

        swm_pkg::S_CAND_RD: begin
          scan_idx <= '0;
          state    <= swm_pkg::S_CAND_LD;
        end

        swm_pkg::S_CAND_LD: begin
          // Candidate arrives; slot zero is being read for the scan.
          cand     <= rd_data;
          less_cnt <= '0;
          le_cnt   <= '0;
          scan_idx <= CW'(1);
          state    <= swm_pkg::S_SCAN;
        end

        swm_pkg::S_SCAN: begin
          // rd_data holds slot scan_idx-1.
          less_cnt <= less_cnt + CW'(cmp_less);
          le_cnt   <= le_cnt + CW'(cmp_le);
          if (scan_idx == held) begin
            state <= swm_pkg::S_CHECK;
          end else begin
            scan_idx <= scan_idx + CW'(1);
          end
        end

        swm_pkg::S_CHECK: begin
          // The candidate covers ranks less_cnt .. le_cnt-1.
          if (less_cnt <= rank_lo && le_cnt > rank_lo) begin
            lo_val <= cand;
          end
          if (less_cnt <= rank_hi && le_cnt > rank_hi) begin
            hi_val <= cand;
          end
          if (CW'(cand_idx) == held - CW'(1)) begin
            state <= swm_pkg::S_FIN;
          end else begin
            cand_idx <= cand_idx + AW'(1);
            state    <= swm_pkg::S_CAND_RD;
          end
        end

        swm_pkg::S_FIN: begin
          // Hold here while an earlier result is still waiting.
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= swm_pkg::S_IDLE;
          end
        end

        default: begin
          state <= swm_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Result payload, loaded as the sequencer finishes.
  always_ff @(posedge clk) begin
    if (state == swm_pkg::S_FIN && out_free) begin
      median_doubled <= swm_pkg::MED_W'(lo_val) + swm_pkg::MED_W'(hi_val);
      fill_count     <= swm_pkg::COUNT_W'(held);
    end
  end

endmodule

/* rtl/core/swm_checker.sv */
// Port-level checker for the sliding window median block, bound to its top.
// Depends on swm_pkg and sliding_window_median_top_assert.svh.
`timescale 1ns / 1ps
`include "sliding_window_median_top_assert.svh"

module swm_checker #(
  parameter int WINDOW = 5
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 item_valid,
  input logic                                 item_ready,
  input logic                                 kind,
  input logic signed [swm_pkg::SAMPLE_W-1:0]  sample,
  input logic                                 result_valid,
  input logic                                 result_ready,
  input logic signed [swm_pkg::MED_W-1:0]     median_doubled,
  input logic        [swm_pkg::COUNT_W-1:0]   fill_count
);

  logic push_xfer;
  logic sample_seen;

  assign push_xfer   = item_valid && item_ready && (kind == swm_pkg::KIND_PUSH);
  assign sample_seen = (sample == sample);

  // A reported count lies between one and the window size.
  `SWM_ASSERT_SAME(a_count_range, result_valid,
                   fill_count != '0 && fill_count <= swm_pkg::COUNT_W'(WINDOW))

  // An odd doubled median only comes from an even count.
  `SWM_ASSERT_SAME(a_odd_sum_even_count, result_valid && median_doubled[0],
                   !fill_count[0])

  // A push keeps the block busy on the next cycle.
  `SWM_ASSERT_NEXT(a_busy_after_push, push_xfer && sample_seen, !item_ready)

  // A stalled result stays offered.
  `SWM_ASSERT_NEXT(a_result_holds, result_valid && !result_ready, result_valid)

endmodule

bind sliding_window_median_top swm_checker #(.WINDOW(WINDOW)) u_swm_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item_valid),
  .item_ready     (item_ready),
  .kind           (kind),
  .sample         (sample),
  .result_valid   (result_valid),
  .result_ready   (result_ready),
  .median_doubled (median_doubled),
  .fill_count     (fill_count)
);
